/* hdl/gnms_pkg.sv */
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared types and constants of the gradient non-maximum suppression block.
// ----------------------------------------------------------------------------
package gnms_pkg;

   // Frame limits and derived widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 11;

   // Payload widths
   localparam int MAG_W = 16;
   localparam int ANG_W = 15;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH       = 2'd0,
      CSR_FRAME_HEIGHT      = 2'd1,
      CSR_DEFAULT_NEIGHBOUR = 2'd2
   } csr_index_type;

   // Reset values of the registers
   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);
   localparam logic [MAG_W-1:0] NEIGHBOUR_RESET    = MAG_W'(255);

   // Angle thresholds in Q3.12 radians, rounded to nearest
   localparam logic signed [ANG_W:0] ANG_PI  = 16'sd12868;
   localparam logic signed [ANG_W:0] ANG_22  = 16'sd1608;
   localparam logic signed [ANG_W:0] ANG_67  = 16'sd4825;
   localparam logic signed [ANG_W:0] ANG_112 = 16'sd8042;
   localparam logic signed [ANG_W:0] ANG_157 = 16'sd11259;

   // Quantized gradient direction
   typedef enum logic [2:0] {
      DIR_HORIZONTAL,
      DIR_DIAG_RISING,
      DIR_VERTICAL,
      DIR_DIAG_FALLING,
      DIR_NONE
   } direction_type;

   // One line buffer entry: two magnitude lines and the angle line
   typedef struct packed {
      logic [MAG_W-1:0] newer;
      logic [MAG_W-1:0] older;
      logic [ANG_W-1:0] angle;
   } line_entry_type;

   // New window column handed to the window stage
   typedef struct packed {
      logic             shift;
      logic [MAG_W-1:0] older;
      logic [MAG_W-1:0] newer;
      logic [MAG_W-1:0] mag;
      logic [ANG_W-1:0] angle;
   } window_column_type;

endpackage

/* hdl/gnms_req_if.sv */
// ----------------------------------------------------------------------------
// gnms_req_if
// Request channel: gradient magnitude and angle of one pixel.
// ----------------------------------------------------------------------------
interface gnms_req_if;
   logic                valid;
   logic                ready;
   logic [15:0]         magnitude;
   logic signed [14:0]  angle;

   modport source (output valid, output magnitude, output angle, input ready);
   modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

/* hdl/gnms_rsp_if.sv */
// ----------------------------------------------------------------------------
// gnms_rsp_if
// Response channel: suppressed magnitude of one interior pixel.
// ----------------------------------------------------------------------------
interface gnms_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;
   logic [9:0]  pixel_row;
   logic [9:0]  pixel_col;
   logic        last_of_frame;

   modport source (output valid, output value, output pixel_row, output pixel_col,
                   output last_of_frame, input ready);
   modport sink   (input valid, input value, input pixel_row, input pixel_col,
                   input last_of_frame, output ready);
endinterface

/* hdl/gradient_non_max_suppression_top.sv */
// ----------------------------------------------------------------------------
// gradient_non_max_suppression_top
// Canny non-maximum suppression over a raster-order gradient stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless a held response stalls it: a request is
// read from the line buffer memory (one entry per column holding two
// magnitude lines and the angle line) in the cycle it is accepted, and as
// stage one moves on the entry is written back and the 3x3 window shifts,
// so the sustained rate is one pixel per cycle, set by the single read and
// write port of that memory. A response is for the pixel one row up, one
// column left; border pixels give none. Frame width and height are clamped
// to [3, 1024]; change registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression_top (
   input  logic                               clock,
   input  logic                               reset,
   gnms_req_if.sink                           req,
   gnms_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [gnms_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [gnms_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gnms_pkg::*;

   // Configuration registers
   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;
   logic [MAG_W-1:0] neighbour_ff;

   // Effective sizes
   logic [DIM_W-1:0] width_eff;
   logic [DIM_W-1:0] height_eff;
   logic [COL_W-1:0] col_last;
   logic [ROW_W-1:0] row_last;

   // Position of the next request
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Stage one: request waiting for its line buffer entry
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [MAG_W-1:0] s1_mag_ff;
   logic [ANG_W-1:0] s1_ang_ff;
   logic             s1_emit;
   logic             s1_adv;
   logic             s1_go;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0] rsp_value_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic             rsp_last_ff;
   logic             out_free;

   logic              accept;
   line_entry_type    rd_entry;
   line_entry_type    wr_entry;
   window_column_type column;
   logic [MAG_W-1:0]  win_value;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         neighbour_ff    <= NEIGHBOUR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:       frame_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:      frame_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_DEFAULT_NEIGHBOUR: neighbour_ff    <= csr_wdata[MAG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp sizes and derive the last column and row
   always_comb begin
      if (frame_width_ff < DIM_W'(3)) begin
         width_eff = DIM_W'(3);
      end else if (frame_width_ff > DIM_W'(MAX_WIDTH)) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff < DIM_W'(3)) begin
         height_eff = DIM_W'(3);
      end else if (frame_height_ff > DIM_W'(MAX_HEIGHT)) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = frame_height_ff;
      end
      col_last = COL_W'(width_eff - DIM_W'(1));
      row_last = ROW_W'(height_eff - DIM_W'(1));
   end

   // Handshake and stage control
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_emit   = (s1_row_ff >= ROW_W'(2)) && (s1_col_ff >= COL_W'(2));
   assign s1_adv    = !s1_emit || out_free;
   assign s1_go     = s1_valid_ff && s1_adv;
   assign req.ready = !s1_valid_ff || s1_adv;
   assign accept    = req.valid && req.ready;

   // Advance the raster position per request
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= col_last) begin
            col_in = '0;
            row_in = (row_ff >= row_last) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage one: hold the request while its entry is read
   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         s1_mag_ff <= req.magnitude;
         s1_ang_ff <= req.angle;
      end
   end

   // Line buffer: read on accept, write back when stage one moves on
   assign wr_entry.newer = s1_mag_ff;
   assign wr_entry.older = rd_entry.newer;
   assign wr_entry.angle = s1_ang_ff;

   gnms_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_entry),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (wr_entry)
   );

   // Window and suppression
   assign column.shift = s1_go;
   assign column.older = rd_entry.older;
   assign column.newer = rd_entry.newer;
   assign column.mag   = s1_mag_ff;
   assign column.angle = rd_entry.angle;

   gnms_window u_window (
      .clock             (clock),
      .reset             (reset),
      .column            (column),
      .default_neighbour (neighbour_ff),
      .value             (win_value)
   );

   // Response register: load interior results, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit) begin
         rsp_value_ff <= win_value;
         rsp_row_ff   <= s1_row_ff - ROW_W'(1);
         rsp_col_ff   <= s1_col_ff - COL_W'(1);
         rsp_last_ff  <= (s1_row_ff >= row_last) && (s1_col_ff >= col_last);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.value         = rsp_value_ff;
   assign rsp.pixel_row     = rsp_row_ff;
   assign rsp.pixel_col     = rsp_col_ff;
   assign rsp.last_of_frame = rsp_last_ff;

endmodule

/* hdl/gnms_line_mem.sv */
// ----------------------------------------------------------------------------
// gnms_line_mem
// Line buffer memory: one entry per column, one read and one write port,
// registered read data.
// ----------------------------------------------------------------------------
module gnms_line_mem (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [gnms_pkg::COL_W-1:0]    rd_addr,
   output gnms_pkg::line_entry_type      rd_data,
   input  logic                          wr_en,
   input  logic [gnms_pkg::COL_W-1:0]    wr_addr,
   input  gnms_pkg::line_entry_type      wr_data
);
   import gnms_pkg::*;

   line_entry_type mem [MAX_WIDTH];
   line_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/gnms_window.sv */
// ----------------------------------------------------------------------------
// gnms_window
// 3x3 magnitude window and center angle; quantizes the direction and
// suppresses the center unless it is a local maximum along it.
// ----------------------------------------------------------------------------
module gnms_window (
   input  logic                          clock,
   input  logic                          reset,
   input  gnms_pkg::window_column_type   column,
   input  logic [gnms_pkg::MAG_W-1:0]    default_neighbour,
   output logic [gnms_pkg::MAG_W-1:0]    value
);
   import gnms_pkg::*;

   // Middle and right columns; the left column is read as the old middle
   logic [MAG_W-1:0] w01_ff, w02_ff, w11_ff, w12_ff, w21_ff, w22_ff;
   logic [ANG_W-1:0] ang_ff;

   logic signed [ANG_W:0] ang_ext;
   logic signed [ANG_W:0] ang_fold;
   direction_type         dir;
   logic [MAG_W-1:0]      center;
   logic [MAG_W-1:0]      nb_q;
   logic [MAG_W-1:0]      nb_r;

   // Shift the window left and load the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         w01_ff <= '0;
         w02_ff <= '0;
         w11_ff <= '0;
         w12_ff <= '0;
         w21_ff <= '0;
         w22_ff <= '0;
         ang_ff <= '0;
      end else if (column.shift) begin
         w01_ff <= w02_ff;
         w02_ff <= column.older;
         w11_ff <= w12_ff;
         w12_ff <= column.newer;
         w21_ff <= w22_ff;
         w22_ff <= column.mag;
         ang_ff <= column.angle;
      end
   end

   // Fold the angle into [0, pi] and quantize it; angles outside [-pi, pi] give no direction
   always_comb begin
      ang_ext  = {ang_ff[ANG_W-1], ang_ff};
      ang_fold = (ang_ext < 0) ? ang_ext + ANG_PI : ang_ext;
      if (ang_fold < 0 || ang_fold > ANG_PI) begin
         dir = DIR_NONE;
      end else if (ang_fold < ANG_22 || ang_fold >= ANG_157) begin
         dir = DIR_HORIZONTAL;
      end else if (ang_fold < ANG_67) begin
         dir = DIR_DIAG_RISING;
      end else if (ang_fold < ANG_112) begin
         dir = DIR_VERTICAL;
      end else begin
         dir = DIR_DIAG_FALLING;
      end
   end

   // Pick the neighbours of the window as it stands after this shift
   always_comb begin
      center = w12_ff;
      unique case (dir)
         DIR_HORIZONTAL: begin
            nb_q = column.newer;
            nb_r = w11_ff;
         end
         DIR_DIAG_RISING: begin
            nb_q = w21_ff;
            nb_r = column.older;
         end
         DIR_VERTICAL: begin
            nb_q = w22_ff;
            nb_r = w02_ff;
         end
         DIR_DIAG_FALLING: begin
            nb_q = w01_ff;
            nb_r = column.mag;
         end
         default: begin
            nb_q = default_neighbour;
            nb_r = default_neighbour;
         end
      endcase
      value = (center >= nb_q && center >= nb_r) ? center : '0;
   end

endmodule
